@@ src/lkvc_pkg.sv @@
`default_nettype none

package lkvc_pkg;

  localparam int unsigned MAX_ENTRIES = 16;
  localparam int unsigned KEY_BITS    = 32;
  localparam int unsigned VALUE_BITS  = 32;
  localparam int unsigned IDX_BITS    = $clog2(MAX_ENTRIES);
  localparam int unsigned RANK_BITS   = IDX_BITS;
  localparam int unsigned CNT_BITS    = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned CAP_BITS    = 5;

  localparam logic [CAP_BITS-1:0] CAP_RESET = CAP_BITS'(MAX_ENTRIES);

  typedef enum logic {
    OP_GET = 1'b0,
    OP_PUT = 1'b1
  } op_t;

  typedef logic signed [KEY_BITS-1:0]   key_t;
  typedef logic signed [VALUE_BITS-1:0] value_t;

endpackage

`default_nettype wire

@@ src/lkvc_ifs.sv @@
`default_nettype none

interface lkvc_req_if;
  logic            valid;
  logic            ready;
  lkvc_pkg::op_t   op;
  lkvc_pkg::key_t  key;
  lkvc_pkg::value_t value_in;

  modport source (output valid, output op, output key, output value_in, input ready);
  modport sink   (input valid, input op, input key, input value_in, output ready);
endinterface

interface lkvc_rsp_if;
  logic             valid;
  logic             ready;
  logic             hit;
  lkvc_pkg::value_t value_out;
  logic             evicted;
  lkvc_pkg::key_t   evicted_key;

  modport source (output valid, output hit, output value_out, output evicted,
                  output evicted_key, input ready);
  modport sink   (input valid, input hit, input value_out, input evicted,
                  input evicted_key, output ready);
endinterface

interface lkvc_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [lkvc_pkg::CAP_BITS-1:0]     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ src/lru_key_value_cache.sv @@
`default_nettype none

// Fully associative key-value cache with least-recently-used replacement,
// 16 entries. Each request beat (get or put) gives exactly one response beat,
// in order. A request is registered, then looked up and applied by a parallel
// compare of all keys and a per-entry rank update, and the response is
// registered: one request per cycle sustained while rsp.ready holds. The
// capacity register (reset 16, 0 acts as 1, above 16 acts as 16) should only
// be written while no request is in flight.

module lru_key_value_cache (
  input  wire               clk,
  input  wire               rst,
  lkvc_req_if.sink          req,
  lkvc_rsp_if.source        rsp,
  lkvc_cfg_if.sink          cfg
);

  localparam int unsigned N  = lkvc_pkg::MAX_ENTRIES;
  localparam int unsigned IW = lkvc_pkg::IDX_BITS;
  localparam int unsigned RW = lkvc_pkg::RANK_BITS;
  localparam int unsigned CW = lkvc_pkg::CNT_BITS;
  localparam int unsigned PW = lkvc_pkg::CAP_BITS;

  // configuration
  logic [PW-1:0] capacity;

  // request register
  logic              s1_valid;
  lkvc_pkg::op_t     s1_op;
  lkvc_pkg::key_t    s1_key;
  lkvc_pkg::value_t  s1_value;

  // store
  lkvc_pkg::key_t    entry_keys   [N];
  lkvc_pkg::value_t  entry_values [N];
  logic [N-1:0]      entry_valid;
  logic [RW-1:0]     recency_rank [N];
  logic [CW-1:0]     entry_count;

  // response register
  logic              out_valid;
  logic              out_hit;
  lkvc_pkg::value_t  out_value;
  logic              out_evicted;
  lkvc_pkg::key_t    out_evicted_key;

  logic              s1_fire;
  logic              in_fire;
  logic [N-1:0]      match;
  logic              hit_any;
  logic [IW-1:0]     found_idx;
  logic [IW-1:0]     victim_idx;
  logic [IW-1:0]     free_idx;
  logic [IW-1:0]     slot_idx;
  logic [CW-1:0]     eff_cap;
  logic [CW-1:0]     cnt_m1;
  logic              is_put;
  logic              evict;
  logic              insert;
  logic [RW-1:0]     hit_rank;
  logic [RW-1:0]     recency_rank_next [N];
  logic [N-1:0]      entry_valid_next;
  logic [CW-1:0]     entry_count_next;

  assign s1_fire = s1_valid && (!out_valid || rsp.ready);
  assign req.ready = !s1_valid || s1_fire;
  assign in_fire = req.valid && req.ready;
  assign cfg.ready = 1'b1;

  assign rsp.valid       = out_valid;
  assign rsp.hit         = out_hit;
  assign rsp.value_out   = out_value;
  assign rsp.evicted     = out_evicted;
  assign rsp.evicted_key = out_evicted_key;

  always_comb begin
    if (capacity == '0) begin
      eff_cap = CW'(1);
    end else if ({{(CW > PW ? CW - PW : 0){1'b0}}, capacity} > CW'(N)) begin
      eff_cap = CW'(N);
    end else begin
      eff_cap = CW'(capacity);
    end
  end

  assign cnt_m1 = entry_count - CW'(1);
  assign is_put = (s1_op == lkvc_pkg::OP_PUT);

  always_comb begin
    found_idx  = '0;
    victim_idx = '0;
    free_idx   = '0;
    hit_rank   = '0;
    for (int i = 0; i < N; i++) begin
      match[i] = entry_valid[i] && (entry_keys[i] == s1_key);
      if (match[i]) begin
        found_idx = found_idx | IW'(i);
        hit_rank  = hit_rank | recency_rank[i];
      end
      if (entry_valid[i] && (CW'(recency_rank[i]) == cnt_m1)) begin
        victim_idx = victim_idx | IW'(i);
      end
    end
    for (int i = N - 1; i >= 0; i--) begin
      if (!entry_valid[i]) begin
        free_idx = IW'(i);
      end
    end
  end

  assign hit_any  = |match;
  assign evict    = is_put && !hit_any && (entry_count >= eff_cap) && (entry_count != '0);
  assign insert   = is_put && !hit_any;
  assign slot_idx = evict ? victim_idx : free_idx;

  always_comb begin
    entry_valid_next = entry_valid;
    entry_count_next = entry_count;
    for (int i = 0; i < N; i++) begin
      recency_rank_next[i] = recency_rank[i];
    end
    if (hit_any) begin
      for (int i = 0; i < N; i++) begin
        if (match[i]) begin
          recency_rank_next[i] = '0;
        end else if (entry_valid[i] && (recency_rank[i] < hit_rank)) begin
          recency_rank_next[i] = recency_rank[i] + RW'(1);
        end
      end
    end else if (insert) begin
      for (int i = 0; i < N; i++) begin
        if (IW'(i) == slot_idx) begin
          recency_rank_next[i] = '0;
        end else if (entry_valid[i]) begin
          recency_rank_next[i] = recency_rank[i] + RW'(1);
        end
      end
      entry_valid_next[slot_idx] = 1'b1;
      if (!evict) begin
        entry_count_next = entry_count + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity    <= lkvc_pkg::CAP_RESET;
      s1_valid    <= 1'b0;
      out_valid   <= 1'b0;
      entry_valid <= '0;
      entry_count <= '0;
      for (int i = 0; i < N; i++) begin
        recency_rank[i] <= '0;
      end
    end else begin
      if (cfg.valid) begin
        capacity <= cfg.data;
      end
      if (in_fire) begin
        s1_valid <= 1'b1;
      end else if (s1_fire) begin
        s1_valid <= 1'b0;
      end
      if (s1_fire) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      if (s1_fire) begin
        entry_valid <= entry_valid_next;
        entry_count <= entry_count_next;
        for (int i = 0; i < N; i++) begin
          recency_rank[i] <= recency_rank_next[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_op    <= req.op;
      s1_key   <= req.key;
      s1_value <= req.value_in;
    end
    if (s1_fire) begin
      out_hit         <= hit_any;
      out_value       <= (hit_any && !is_put) ? entry_values[found_idx] : '1;
      out_evicted     <= evict;
      out_evicted_key <= evict ? entry_keys[victim_idx] : '0;
      if (hit_any && is_put) begin
        entry_values[found_idx] <= s1_value;
      end else if (insert) begin
        entry_keys[slot_idx]   <= s1_key;
        entry_values[slot_idx] <= s1_value;
      end
    end
  end

  a_count_matches_valid: assert property (@(posedge clk) disable iff (rst)
    $countones(entry_valid) == 32'(entry_count))
    else $error("entry count differs from number of valid entries");

  a_single_match: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> $onehot0(match))
    else $error("key stored in more than one entry");

  a_evict_keeps_count: assert property (@(posedge clk) disable iff (rst)
    (s1_fire && evict) |=> (entry_count == $past(entry_count)))
    else $error("eviction changed entry count");

  a_hit_not_evicted: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_hit && out_evicted))
    else $error("response both hit and evicted");

endmodule

`default_nettype wire

@@ test/tb_lru_key_value_cache.sv @@
module tb_lru_key_value_cache;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_ITEMS = 125;
  localparam int CAP_W       = lkvc_pkg::CAP_BITS;
  localparam int ENTRIES     = lkvc_pkg::MAX_ENTRIES;

  typedef struct {
    logic             hit;
    lkvc_pkg::value_t value_out;
    logic             evicted;
    lkvc_pkg::key_t   evicted_key;
  } rsp_beat_t;

  class lru_scoreboard;
    lkvc_pkg::key_t       keys [ENTRIES];
    lkvc_pkg::value_t     vals [ENTRIES];
    bit                   live [ENTRIES];
    int unsigned          rank [ENTRIES];
    int unsigned          count;
    logic [CAP_W-1:0]     capacity;
    int                   errors;
    rsp_beat_t            rsp_due [$];

    function new();
      capacity = lkvc_pkg::CAP_RESET;
      count    = 0;
      errors   = 0;
      foreach (live[i]) begin
        live[i] = 1'b0;
        rank[i] = 0;
      end
    endfunction

    function void set_capacity(logic [CAP_W-1:0] c);
      capacity = c;
    endfunction

    function int unsigned limit();
      int unsigned c;
      c = 32'(capacity);
      if (c == 0) c = 1;
      if (c > ENTRIES) c = ENTRIES;
      return c;
    endfunction

    // move entry s to the front, entries ahead of it age by one
    function void promote(int s);
      int unsigned r;
      r = rank[s];
      foreach (live[i])
        if (live[i] && rank[i] < r) rank[i]++;
      rank[s] = 0;
    endfunction

    function void note_request(lkvc_pkg::op_t op, lkvc_pkg::key_t k, lkvc_pkg::value_t v);
      rsp_beat_t   r;
      int          found;
      int          slot;
      int unsigned oldest;
      r.hit         = 1'b0;
      r.value_out   = '1;
      r.evicted     = 1'b0;
      r.evicted_key = '0;
      found         = -1;
      slot          = -1;
      foreach (live[i])
        if (found < 0 && live[i] && keys[i] == k) found = i;
      if (found >= 0) begin
        r.hit = 1'b1;
        if (op == lkvc_pkg::OP_GET) r.value_out = vals[found];
        else vals[found] = v;
        promote(found);
      end else if (op == lkvc_pkg::OP_PUT) begin
        if (count >= limit() && count > 0) begin
          oldest = 0;
          foreach (live[i])
            if (live[i] && (slot < 0 || rank[i] > oldest)) begin
              slot   = i;
              oldest = rank[i];
            end
          r.evicted     = 1'b1;
          r.evicted_key = keys[slot];
          live[slot]    = 1'b0;
          count--;
        end else begin
          foreach (live[i])
            if (slot < 0 && !live[i]) slot = i;
        end
        if (slot >= 0) begin
          foreach (live[i])
            if (live[i]) rank[i]++;
          keys[slot] = k;
          vals[slot] = v;
          live[slot] = 1'b1;
          rank[slot] = 0;
          count++;
        end
      end
      rsp_due.push_back(r);
    endfunction

    function void check_response(rsp_beat_t got);
      rsp_beat_t want;
      if (rsp_due.size() == 0) begin
        errors++;
        $display("%0t: response beat with none due: expected nothing, actual hit=%b value_out=%h",
                 $time, got.hit, got.value_out);
        return;
      end
      want = rsp_due.pop_front();
      if (got.hit !== want.hit) begin
        errors++;
        $display("%0t: hit expected %b actual %b", $time, want.hit, got.hit);
      end
      if (got.value_out !== want.value_out) begin
        errors++;
        $display("%0t: value_out expected %h actual %h", $time, want.value_out, got.value_out);
      end
      if (got.evicted !== want.evicted) begin
        errors++;
        $display("%0t: evicted expected %b actual %b", $time, want.evicted, got.evicted);
      end
      if (got.evicted_key !== want.evicted_key) begin
        errors++;
        $display("%0t: evicted_key expected %h actual %h", $time, want.evicted_key,
                 got.evicted_key);
      end
    endfunction

    function int pending();
      return rsp_due.size();
    endfunction
  endclass

  logic clk;
  logic rst;

  lkvc_req_if req_ch ();
  lkvc_rsp_if rsp_ch ();
  lkvc_cfg_if cfg_ch ();

  lru_key_value_cache DUT (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  lru_scoreboard  sb;
  bit             no_gaps;
  int             stall_request;
  int             hold_left;
  int             cycles;
  lkvc_pkg::key_t key_pool [32];

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // response side: random back-pressure plus long hold-offs on request
  always @(negedge clk) begin
    if (stall_request > 0) begin
      hold_left     = stall_request;
      stall_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= no_gaps || ($urandom_range(0, 99) >= 20);
    end
  end

  always @(posedge clk) begin
    rsp_beat_t got;
    if (!rst && rsp_ch.valid === 1'b1 && rsp_ch.ready) begin
      got.hit         = rsp_ch.hit;
      got.value_out   = rsp_ch.value_out;
      got.evicted     = rsp_ch.evicted;
      got.evicted_key = rsp_ch.evicted_key;
      sb.check_response(got);
    end
  end

  task automatic send_req(input lkvc_pkg::op_t op, input lkvc_pkg::key_t k,
                          input lkvc_pkg::value_t v);
    @(negedge clk);
    while (!no_gaps && $urandom_range(0, 99) < 20) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.op       <= op;
    req_ch.key      <= k;
    req_ch.value_in <= v;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    sb.note_request(op, k, v);
  endtask

  task automatic wait_drain();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] c);
    wait_drain();
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= c;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    sb.set_capacity(c);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // keys mostly from a small pool sized near the capacity so hits and evictions mix
  task automatic random_phase(input logic [CAP_W-1:0] cap, input int phase);
    int             n;
    int             base;
    lkvc_pkg::op_t  op;
    lkvc_pkg::key_t k;
    write_capacity(cap);
    n    = sb.limit() + $urandom_range(1, 6);
    base = $urandom_range(0, 31);
    no_gaps = (phase == 3);
    for (int j = 0; j < PHASE_ITEMS; j++) begin
      if (phase == 2 && j == 40) stall_request = 80;
      if (phase == 5 && j == 60) wait_drain();
      op = ($urandom_range(0, 99) < 55) ? lkvc_pkg::OP_PUT : lkvc_pkg::OP_GET;
      if ($urandom_range(0, 9) == 0) k = $urandom;
      else k = key_pool[(base + $urandom_range(0, n - 1)) % 32];
      send_req(op, k, $urandom);
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    logic [CAP_W-1:0] caps [8];
    clk             = 1'b0;
    rst             = 1'b1;
    no_gaps         = 1'b0;
    stall_request   = 0;
    hold_left       = 0;
    cycles          = 0;
    req_ch.valid    = 1'b0;
    req_ch.op       = lkvc_pkg::OP_GET;
    req_ch.key      = '0;
    req_ch.value_in = '0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.data     = '0;
    rsp_ch.ready    = 1'b0;
    sb = new();

    key_pool[0] = 32'sh8000_0000;
    key_pool[1] = 32'sh7fff_ffff;
    key_pool[2] = '0;
    key_pool[3] = '1;
    for (int i = 4; i < 32; i++) key_pool[i] = $urandom;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset capacity, empty store, extreme keys and values
    send_req(lkvc_pkg::OP_GET, '0, '0);
    send_req(lkvc_pkg::OP_PUT, 32'sh8000_0000, 32'sh7fff_ffff);
    send_req(lkvc_pkg::OP_PUT, 32'sh7fff_ffff, 32'sh8000_0000);
    send_req(lkvc_pkg::OP_PUT, '0, '1);
    send_req(lkvc_pkg::OP_GET, 32'sh8000_0000, '0);
    send_req(lkvc_pkg::OP_GET, 32'sh7fff_ffff, '1);
    send_req(lkvc_pkg::OP_GET, '0, '0);
    send_req(lkvc_pkg::OP_PUT, 32'sh7fff_ffff, '0);
    send_req(lkvc_pkg::OP_GET, 32'sh7fff_ffff, '0);
    send_req(lkvc_pkg::OP_GET, '1, '0);

    // store full at capacity three
    write_capacity(5'd3);
    send_req(lkvc_pkg::OP_PUT, 32'sh1234_5678, 32'sh5555_5555);
    send_req(lkvc_pkg::OP_GET, '0, '0);
    send_req(lkvc_pkg::OP_PUT, 32'sh5555_5555, 32'shaaaa_aaaa);

    // capacity lowered below the entry count
    write_capacity(5'd1);
    send_req(lkvc_pkg::OP_PUT, 32'shaaaa_aaaa, 32'sh0000_0001);
    send_req(lkvc_pkg::OP_GET, 32'sh5555_5555, '0);
    send_req(lkvc_pkg::OP_PUT, 32'shaaaa_aaaa, 32'shffff_fffe);
    send_req(lkvc_pkg::OP_GET, 32'shaaaa_aaaa, '0);

    // zero acts as one
    write_capacity(5'd0);
    send_req(lkvc_pkg::OP_PUT, '1, 32'sh0f0f_0f0f);
    send_req(lkvc_pkg::OP_GET, 32'sh1234_5678, '0);
    send_req(lkvc_pkg::OP_GET, '1, '0);

    // above the entry limit saturates
    write_capacity(5'd31);
    send_req(lkvc_pkg::OP_PUT, 32'sh0000_0001, 32'sh7fff_ffff);
    send_req(lkvc_pkg::OP_PUT, 32'sh8000_0000, 32'sh8000_0000);
    send_req(lkvc_pkg::OP_GET, 32'sh0000_0001, '0);

    caps[0] = 5'd31;
    caps[1] = 5'd1;
    caps[2] = 5'd16;
    caps[3] = 5'd5;
    caps[4] = 5'd0;
    caps[5] = 5'd17;
    caps[6] = 5'd2;
    caps[7] = CAP_W'($urandom_range(0, 31));
    for (int p = 0; p < 8; p++) random_phase(caps[p], p);

    wait_drain();
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
